// File: hw/rtl/sll_pkg.sv
package sll_pkg;

  localparam int MAX_LEN = 64;
  localparam int OUT_CAP = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int CMP_W   = CNT_W + 1;
  localparam int OUT_W   = $clog2(OUT_CAP);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNTERM = 2'd1;
  localparam logic [1:0] ST_LONG   = 2'd2;
  localparam logic [1:0] ST_BADESC = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h5c;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6e;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_BSP   = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] status;
    logic       last;
    logic       terminator_returned;
  } out_t;

  typedef enum logic [1:0] {
    S_SCAN,
    S_READ,
    S_LOOK,
    S_SEND
  } state_t;

  typedef struct packed {
    logic scan;
    logic rd;
    logic look;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic closes;
    logic skip;
    logic last;
  } sts_t;

  function automatic logic esc_char_ok(input logic [7:0] c);
    esc_char_ok = (c == CH_LC_B) || (c == CH_LC_F) || (c == CH_LC_N) ||
                  (c == CH_LC_R) || (c == CH_LC_T) || (c == CH_BS) ||
                  (c == CH_SQ) || (c == CH_DQ);
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    case (c)
      CH_LC_B: decode_escape = CH_BSP;
      CH_LC_F: decode_escape = CH_FF;
      CH_LC_N: decode_escape = CH_NL;
      CH_LC_R: decode_escape = CH_CR;
      CH_LC_T: decode_escape = CH_TAB;
      default: decode_escape = c;
    endcase
  endfunction

endpackage

// File: hw/rtl/sll_ctrl.sv
module sll_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  sll_pkg::sts_t  sts,
  output sll_pkg::cmd_t  cmd
);

  sll_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sll_pkg::S_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      sll_pkg::S_SCAN: begin
        in_ready = 1'b1;
        cmd.scan = in_valid;
        if (in_valid && sts.closes) begin
          state_nxt = sll_pkg::S_READ;
        end
      end
      sll_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = sll_pkg::S_LOOK;
      end
      sll_pkg::S_LOOK: begin
        cmd.look = 1'b1;
        // escape lead-in: fetch the escaped character instead of sending
        state_nxt = sts.skip ? sll_pkg::S_READ : sll_pkg::S_SEND;
      end
      sll_pkg::S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.adv   = 1'b1;
          state_nxt = sts.last ? sll_pkg::S_SCAN : sll_pkg::S_READ;
        end
      end
      default: begin
        state_nxt = sll_pkg::S_SCAN;
      end
    endcase
  end

endmodule

// File: hw/rtl/sll_dpath.sv
module sll_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  sll_pkg::in_t   in_data,
  input  sll_pkg::cmd_t  cmd,
  output sll_pkg::sts_t  sts,
  output sll_pkg::out_t  out_data
);

  logic [7:0]                  mem [sll_pkg::MAX_LEN];
  logic [sll_pkg::CNT_W-1:0]   cnt_r;
  logic                        inside_r;
  logic                        esc_open_r;
  logic                        bad_r;
  logic                        ovf_r;
  logic [1:0]                  status_r;
  logic                        term_r;
  logic [sll_pkg::ADDR_W-1:0]  ptr_r;
  logic [sll_pkg::OUT_W-1:0]   n_r;
  logic                        dec_esc_r;
  logic [7:0]                  rd_data_r;
  sll_pkg::out_t               out_r;

  logic [7:0]                  c;
  logic                        eoi;
  logic                        full;
  logic                        ovf_nxt;
  logic                        wr_en;
  logic [sll_pkg::CMP_W-1:0]   ptr_ext;
  logic [sll_pkg::CMP_W-1:0]   cnt_ext;
  logic                        at_end;

  assign c        = in_data.char_in;
  assign eoi      = in_data.end_of_input;
  assign full     = (cnt_r == sll_pkg::CNT_W'(sll_pkg::MAX_LEN));
  assign ovf_nxt  = ovf_r | full;
  assign ptr_ext  = sll_pkg::CMP_W'(ptr_r);
  assign cnt_ext  = sll_pkg::CMP_W'(cnt_r);
  assign at_end   = ((ptr_ext + sll_pkg::CMP_W'(1)) == cnt_ext) ||
                    (n_r == sll_pkg::OUT_W'(sll_pkg::OUT_CAP - 1));

  assign sts.closes = inside_r &&
                      (eoi || (c == sll_pkg::CH_NL) ||
                       (!esc_open_r && (c == sll_pkg::CH_DQ)));
  // pair decoding only inside the body, never on opener or closing quote
  assign sts.skip   = (status_r == sll_pkg::ST_OK) && !dec_esc_r &&
                      (ptr_r != '0) &&
                      ((ptr_ext + sll_pkg::CMP_W'(2)) < cnt_ext) &&
                      (rd_data_r == sll_pkg::CH_BS);
  assign sts.last   = out_r.last;
  assign out_data   = out_r;

  assign wr_en = cmd.scan && !eoi &&
                 (!inside_r || ((c != sll_pkg::CH_NL) && !full));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[inside_r ? cnt_r[sll_pkg::ADDR_W-1:0] : '0] <= c;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      inside_r   <= 1'b0;
      esc_open_r <= 1'b0;
      bad_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else if (cmd.scan) begin
      if (!inside_r) begin
        if (!eoi) begin
          cnt_r      <= sll_pkg::CNT_W'(1);
          inside_r   <= 1'b1;
          esc_open_r <= 1'b0;
          bad_r      <= 1'b0;
          ovf_r      <= 1'b0;
        end
      end else if (!eoi && (c != sll_pkg::CH_NL)) begin
        if (!full) begin
          cnt_r <= cnt_r + sll_pkg::CNT_W'(1);
        end
        ovf_r <= ovf_nxt;
        if (esc_open_r) begin
          esc_open_r <= 1'b0;
          if (!sll_pkg::esc_char_ok(c)) begin
            bad_r <= 1'b1;
          end
        end else if (c == sll_pkg::CH_BS) begin
          esc_open_r <= 1'b1;
        end
      end
    end else if (cmd.adv && out_r.last) begin
      cnt_r      <= '0;
      inside_r   <= 1'b0;
      esc_open_r <= 1'b0;
      bad_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && sts.closes) begin
      ptr_r     <= '0;
      n_r       <= '0;
      dec_esc_r <= 1'b0;
      if (eoi || (c == sll_pkg::CH_NL)) begin
        status_r <= ovf_r ? sll_pkg::ST_LONG : sll_pkg::ST_UNTERM;
        term_r   <= !eoi;
      end else begin
        // the closing quote itself may find the store full
        status_r <= ovf_nxt ? sll_pkg::ST_LONG :
                    (bad_r ? sll_pkg::ST_BADESC : sll_pkg::ST_OK);
        term_r   <= 1'b0;
      end
    end else if (cmd.look) begin
      if (sts.skip) begin
        dec_esc_r <= 1'b1;
        ptr_r     <= ptr_r + sll_pkg::ADDR_W'(1);
      end else begin
        dec_esc_r                 <= 1'b0;
        out_r.char_out            <= dec_esc_r ? sll_pkg::decode_escape(rd_data_r)
                                               : rd_data_r;
        out_r.status              <= status_r;
        out_r.last                <= at_end;
        out_r.terminator_returned <= term_r;
      end
    end else if (cmd.adv && !out_r.last) begin
      ptr_r <= ptr_r + sll_pkg::ADDR_W'(1);
      n_r   <= n_r + sll_pkg::OUT_W'(1);
    end
  end

endmodule

// File: hw/rtl/string_literal_lexer.sv
// Scanning: one character per cycle, one request accepted each cycle until the literal closes.
// Emission: each emitted character goes through store read, registered look and send, and a
// decoded escape pair adds one more read and look; the text store has a single read port. No input while emitting.
// After the closing request, read and look come before the first result; back to scanning the cycle after last.
// Reset (rst_n low, synchronous): idle, fill count and scan flags cleared; store contents undefined.
module string_literal_lexer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sll_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sll_pkg::out_t out_data
);

  sll_pkg::cmd_t cmd;
  sll_pkg::sts_t sts;

  sll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sll_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_back_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> (in_ready && !out_valid))
    else $error("no return to scanning after final character");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule
